[hdl/nsc_pkg.sv]
package nsc_pkg;

   typedef struct packed {
      logic [7:0] sentence_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] sentence_kind;
      logic       checksum_match;
      logic [7:0] computed_checksum;
      logic [7:0] received_checksum;
      logic       checksum_present;
   } rsp_type;

   localparam logic [7:0] STAR_CHAR = 8'h2A;

   localparam logic [1:0] KIND_INVALID = 2'd0;
   localparam logic [1:0] KIND_GGA     = 2'd1;
   localparam logic [1:0] KIND_RMC     = 2'd2;
   localparam logic [1:0] KIND_DPT     = 2'd3;

   localparam logic [23:0] LETTERS_GGA = 24'h474741;
   localparam logic [23:0] LETTERS_RMC = 24'h524D43;
   localparam logic [23:0] LETTERS_DPT = 24'h445054;

   localparam logic [1:0] PHASE_MARKER = 2'd0;
   localparam logic [1:0] PHASE_SUM    = 2'd1;
   localparam logic [1:0] PHASE_DIGITS = 2'd2;

   localparam logic [2:0] POS_FULL   = 3'd6;
   localparam logic [2:0] POS_TYPE_LO = 3'd3;
   localparam logic [2:0] POS_TYPE_HI = 3'd5;
   localparam logic [1:0] DIGITS_FULL = 2'd2;

   // Hex digit value, upper or lower case; anything else counts as zero.
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] diff;
      begin
         diff = 8'd0;
         if (c >= 8'd48 && c <= 8'd57) begin
            diff = c - 8'd48;
         end else if (c >= 8'd97 && c <= 8'd102) begin
            diff = c - 8'd87;
         end else if (c >= 8'd65 && c <= 8'd70) begin
            diff = c - 8'd55;
         end
         hex_nibble = diff[3:0];
      end
   endfunction

endpackage

[hdl/nmea_sentence_check_classify.sv]
// The result word is registered: it appears in the cycle after the last byte of a sentence is accepted.
// Throughput: one byte per cycle while input is not stalled; the parse state updates on every accepted byte.
// The result register is the only stall point: input stalls while it is full and stalled.
// Reset (synchronous, active high) clears the parse state to "expecting start marker"
// and empties the result register.
module nmea_sentence_check_classify (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  nsc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output nsc_pkg::rsp_type rsp_data
);

   // Parse state
   logic [1:0]  phase_ff,   phase_in;
   logic [2:0]  pos_ff,     pos_in;
   logic [7:0]  xor_ff,     xor_in;
   logic [23:0] letters_ff, letters_in;
   logic [7:0]  digit_ff,   digit_in;
   logic [1:0]  ndig_ff,    ndig_in;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   nsc_pkg::rsp_type rsp_data_ff,  rsp_data_in;

   // State after this byte, before the end-of-sentence return to reset
   logic [1:0]  phase_nx;
   logic [2:0]  pos_nx;
   logic [7:0]  xor_nx;
   logic [23:0] letters_nx;
   logic [7:0]  digit_nx;
   logic [1:0]  ndig_nx;

   logic       accept;
   logic       present;
   logic       match;
   logic [7:0] received;
   logic [1:0] kind;
   logic [7:0] b;

   // Hold input only while a finished result is waiting and the far side stalls.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign b         = req_data.sentence_byte;

   always_comb begin
      phase_nx   = phase_ff;
      pos_nx     = pos_ff;
      xor_nx     = xor_ff;
      letters_nx = letters_ff;
      digit_nx   = digit_ff;
      ndig_nx    = ndig_ff;

      // Capture type letters at bytes 3 to 5, first one ends up in the top byte.
      if (pos_ff >= nsc_pkg::POS_TYPE_LO && pos_ff <= nsc_pkg::POS_TYPE_HI) begin
         letters_nx = {letters_ff[15:0], b};
      end
      if (pos_ff < nsc_pkg::POS_FULL) begin
         pos_nx = pos_ff + 3'd1;
      end

      case (phase_ff)
         nsc_pkg::PHASE_MARKER: begin
            // Skip the start marker, whatever it is.
            phase_nx = nsc_pkg::PHASE_SUM;
         end
         nsc_pkg::PHASE_SUM: begin
            if (b == nsc_pkg::STAR_CHAR) begin
               phase_nx = nsc_pkg::PHASE_DIGITS;
            end else begin
               xor_nx = xor_ff ^ b;
            end
         end
         default: begin
            // After the star: take two hex digits, drop everything beyond.
            if (ndig_ff < nsc_pkg::DIGITS_FULL) begin
               digit_nx = {digit_ff[3:0], nsc_pkg::hex_nibble(b)};
               ndig_nx  = ndig_ff + 2'd1;
            end
         end
      endcase

      present  = (phase_nx == nsc_pkg::PHASE_DIGITS) && (ndig_nx == nsc_pkg::DIGITS_FULL);
      received = present ? digit_nx : 8'd0;
      match    = present && (received == xor_nx);

      kind = nsc_pkg::KIND_INVALID;
      if (match && pos_nx >= nsc_pkg::POS_FULL) begin
         if (letters_nx == nsc_pkg::LETTERS_GGA) begin
            kind = nsc_pkg::KIND_GGA;
         end else if (letters_nx == nsc_pkg::LETTERS_RMC) begin
            kind = nsc_pkg::KIND_RMC;
         end else if (letters_nx == nsc_pkg::LETTERS_DPT) begin
            kind = nsc_pkg::KIND_DPT;
         end
      end
   end

   // Advance the parse state on every accepted byte; the last byte returns it to reset.
   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      xor_in     = xor_ff;
      letters_in = letters_ff;
      digit_in   = digit_ff;
      ndig_in    = ndig_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            phase_in   = nsc_pkg::PHASE_MARKER;
            pos_in     = 3'd0;
            xor_in     = 8'd0;
            letters_in = 24'd0;
            digit_in   = 8'd0;
            ndig_in    = 2'd0;
         end else begin
            phase_in   = phase_nx;
            pos_in     = pos_nx;
            xor_in     = xor_nx;
            letters_in = letters_nx;
            digit_in   = digit_nx;
            ndig_in    = ndig_nx;
         end
      end
   end

   // Load the result word on the last byte; drop it once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && req_data.last_byte) begin
         rsp_valid_in                  = 1'b1;
         rsp_data_in.sentence_kind     = kind;
         rsp_data_in.checksum_match    = match;
         rsp_data_in.computed_checksum = xor_nx;
         rsp_data_in.received_checksum = received;
         rsp_data_in.checksum_present  = present;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= nsc_pkg::PHASE_MARKER;
         pos_ff       <= 3'd0;
         xor_ff       <= 8'd0;
         letters_ff   <= 24'd0;
         digit_ff     <= 8'd0;
         ndig_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         xor_ff       <= xor_in;
         letters_ff   <= letters_in;
         digit_ff     <= digit_in;
         ndig_ff      <= ndig_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A last byte that is accepted must yield a result word in the next cycle.
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.last_byte |=> rsp_valid_ff)
      else $error("last byte accepted but no result word loaded");

   // The parse state is back at its reset value after a sentence ends.
   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.last_byte |=>
         phase_ff == nsc_pkg::PHASE_MARKER && pos_ff == 3'd0 && ndig_ff == 2'd0)
      else $error("parse state not cleared after last byte");

   // A known kind needs a matching checksum, and a match needs a present checksum.
   a_kind_needs_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.sentence_kind == nsc_pkg::KIND_INVALID ||
                        rsp_data_ff.checksum_match) &&
                       (!rsp_data_ff.checksum_match || rsp_data_ff.checksum_present))
      else $error("result flags inconsistent");

   // Without a checksum the received field reads zero.
   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.checksum_present |->
         rsp_data_ff.received_checksum == 8'd0)
      else $error("received checksum non-zero while absent");

endmodule
